@@ src/sgcs_pkg.sv @@
`timescale 1ns / 1ps

package sgcs_pkg;

  localparam int TimeWidth = 32;
  localparam int AddrWidth = 5;

  typedef logic [TimeWidth-1:0] time_t;

  // register indexes on the configuration port
  typedef enum logic [2:0] {
    REG_NUM_CONFIGS      = 3'd0,
    REG_THROTTLE_LIMIT   = 3'd1,
    REG_CHANGE_THRESHOLD = 3'd2,
    REG_WIGGLE_THRESHOLD = 3'd3,
    REG_HOLD_DELAY       = 3'd4,
    REG_REARM_DELAY      = 3'd5,
    REG_WIGGLE_DECAY     = 3'd6,
    REG_WIGGLES_NEEDED   = 3'd7
  } reg_idx_t;

  localparam logic [3:0]  NumConfigsReset      = 4'd4;
  localparam logic [14:0] ThrottleLimitReset   = 15'd983;
  localparam logic [14:0] ChangeThresholdReset = 15'd26214;
  localparam logic [14:0] WiggleThresholdReset = 15'd2621;
  localparam logic [15:0] HoldDelayReset       = 16'd1500;
  localparam logic [15:0] RearmDelayReset      = 16'd500;
  localparam logic [15:0] WiggleDecayReset     = 16'd1000;
  localparam logic [3:0]  WigglesNeededReset   = 4'd3;

endpackage

@@ src/sgcs_ifs.sv @@
`timescale 1ns / 1ps

interface sgcs_sample_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] tuner;
  logic signed [15:0] thrust;
  logic               buzzer_busy;
  logic [31:0]        now_ms;

  modport source (output valid, tuner, thrust, buzzer_busy, now_ms, input ready);
  modport sink   (input valid, tuner, thrust, buzzer_busy, now_ms, output ready);
endinterface

interface sgcs_result_if;
  logic       valid;
  logic       ready;
  logic       warning_beeps;
  logic       announce_config;
  logic [3:0] config_index;

  modport source (output valid, warning_beeps, announce_config, config_index, input ready);
  modport sink   (input valid, warning_beeps, announce_config, config_index, output ready);
endinterface

@@ src/stick_gesture_config_selector_top.sv @@
`timescale 1ns / 1ps

// channel   dir  handshake      beat contents
// sample    in   valid/ready    tuner, thrust, buzzer_busy, now_ms
// result    out  valid/ready    warning_beeps, announce_config, config_index
// cfg       in   apb write/read num_configs .. wiggles_needed at 4*i
//
// one beat per cycle sustained unless the result stalls; sample register, then
// gesture logic into the result register, state updates as a beat leaves the
// sample register. rst is synchronous: clears valids and gesture state, loads
// register defaults. a stalled result holds both stages; the sample register
// still fills while the result waits.

module stick_gesture_config_selector_top (
  input  logic                          clk,
  input  logic                          rst,
  sgcs_sample_if.sink                   sample,
  sgcs_result_if.source                 result,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [sgcs_pkg::AddrWidth-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import sgcs_pkg::*;

  // configuration registers
  logic [3:0]  num_configs;
  logic [14:0] throttle_limit;
  logic [14:0] change_threshold;
  logic [14:0] wiggle_threshold;
  logic [15:0] hold_delay_ms;
  logic [15:0] rearm_delay_ms;
  logic [15:0] wiggle_decay_ms;
  logic [3:0]  wiggles_needed;

  reg_idx_t reg_sel;
  assign reg_sel = reg_idx_t'(paddr[AddrWidth-1:2]);
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_configs      <= NumConfigsReset;
      throttle_limit   <= ThrottleLimitReset;
      change_threshold <= ChangeThresholdReset;
      wiggle_threshold <= WiggleThresholdReset;
      hold_delay_ms    <= HoldDelayReset;
      rearm_delay_ms   <= RearmDelayReset;
      wiggle_decay_ms  <= WiggleDecayReset;
      wiggles_needed   <= WigglesNeededReset;
    end else if (psel && penable && pwrite) begin
      unique case (reg_sel)
        REG_NUM_CONFIGS:      num_configs      <= pwdata[3:0];
        REG_THROTTLE_LIMIT:   throttle_limit   <= pwdata[14:0];
        REG_CHANGE_THRESHOLD: change_threshold <= pwdata[14:0];
        REG_WIGGLE_THRESHOLD: wiggle_threshold <= pwdata[14:0];
        REG_HOLD_DELAY:       hold_delay_ms    <= pwdata[15:0];
        REG_REARM_DELAY:      rearm_delay_ms   <= pwdata[15:0];
        REG_WIGGLE_DECAY:     wiggle_decay_ms  <= pwdata[15:0];
        REG_WIGGLES_NEEDED:   wiggles_needed   <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_NUM_CONFIGS:      prdata = {28'd0, num_configs};
      REG_THROTTLE_LIMIT:   prdata = {17'd0, throttle_limit};
      REG_CHANGE_THRESHOLD: prdata = {17'd0, change_threshold};
      REG_WIGGLE_THRESHOLD: prdata = {17'd0, wiggle_threshold};
      REG_HOLD_DELAY:       prdata = {16'd0, hold_delay_ms};
      REG_REARM_DELAY:      prdata = {16'd0, rearm_delay_ms};
      REG_WIGGLE_DECAY:     prdata = {16'd0, wiggle_decay_ms};
      REG_WIGGLES_NEEDED:   prdata = {28'd0, wiggles_needed};
      default:              prdata = 32'd0;
    endcase
  end

  // sample register
  logic               s_valid;
  logic signed [15:0] s_tuner;
  logic signed [15:0] s_thrust;
  logic               s_busy;
  time_t              s_now;
  logic               advance;

  assign advance      = s_valid && (!result.valid || result.ready);
  assign sample.ready = !s_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (sample.ready) begin
      s_valid <= sample.valid;
    end
    if (sample.valid && sample.ready) begin
      s_tuner  <= sample.tuner;
      s_thrust <= sample.thrust;
      s_busy   <= sample.buzzer_busy;
      s_now    <= sample.now_ms[TimeWidth-1:0];
    end
  end

  // gesture state
  logic [3:0] current_config;
  logic       waiting_change;
  time_t      warning_start_ms;
  time_t      changed_at_ms;
  logic       upper_side_hit;
  logic       lower_side_hit;
  logic [3:0] wiggle_count;
  time_t      last_decay_ms;

  logic [3:0] current_config_next;
  logic       waiting_change_next;
  time_t      warning_start_ms_next;
  time_t      changed_at_ms_next;
  logic       upper_side_hit_next;
  logic       lower_side_hit_next;
  logic [3:0] wiggle_count_next;
  time_t      last_decay_ms_next;
  logic       warn;
  logic       announce;

  logic signed [16:0] tuner_x;
  logic signed [16:0] cth_pos;
  logic signed [16:0] wth_pos;
  logic               low_throttle;
  logic               zone_high;
  logic               zone_low;
  logic               wig_high;
  logic               wig_low;
  logic [3:0]         count_max;
  logic [4:0]         step_up;
  time_t              since_warning;
  time_t              since_change;
  time_t              since_decay;
  logic [4:0]         wig_cnt;

  always_comb begin
    tuner_x       = {s_tuner[15], s_tuner};
    cth_pos       = $signed({2'b00, change_threshold});
    wth_pos       = $signed({2'b00, wiggle_threshold});
    low_throttle  = $signed({s_thrust[15], s_thrust}) < $signed({2'b00, throttle_limit});
    zone_high     = tuner_x >= cth_pos;
    zone_low      = tuner_x <= -cth_pos;
    wig_high      = tuner_x >= wth_pos;
    wig_low       = tuner_x <= -wth_pos;
    count_max     = (num_configs == 4'd0) ? 4'd1 : num_configs;
    step_up       = {1'b0, current_config} + 5'd1;
    since_warning = s_now - warning_start_ms;
    since_change  = s_now - changed_at_ms;
    since_decay   = s_now - last_decay_ms;

    current_config_next   = current_config;
    waiting_change_next   = waiting_change;
    warning_start_ms_next = warning_start_ms;
    changed_at_ms_next    = changed_at_ms;
    upper_side_hit_next   = upper_side_hit;
    lower_side_hit_next   = lower_side_hit;
    wiggle_count_next     = wiggle_count;
    last_decay_ms_next    = last_decay_ms;
    warn                  = 1'b0;
    announce              = 1'b0;
    wig_cnt               = {1'b0, wiggle_count};

    if (low_throttle && (zone_high || zone_low) && !s_busy) begin
      if (waiting_change) begin
        if (since_warning >= time_t'(hold_delay_ms)) begin
          changed_at_ms_next  = s_now;
          waiting_change_next = 1'b0;
          announce            = 1'b1;
          if (zone_high) begin
            current_config_next = (step_up > {1'b0, count_max}) ? 4'd1 : step_up[3:0];
          end else begin
            current_config_next = (current_config <= 4'd1) ? count_max
                                                           : current_config - 4'd1;
          end
        end
      end else if (since_change >= time_t'(rearm_delay_ms)) begin
        warn                  = 1'b1;
        warning_start_ms_next = s_now;
        waiting_change_next   = 1'b1;
      end
    end

    if (!s_busy) begin
      upper_side_hit_next = upper_side_hit || wig_high;
      lower_side_hit_next = lower_side_hit || wig_low;
      if (upper_side_hit_next && lower_side_hit_next) begin
        upper_side_hit_next = 1'b0;
        lower_side_hit_next = 1'b0;
        wig_cnt             = wig_cnt + 5'd1;
        if (wig_cnt >= {1'b0, wiggles_needed}) begin
          wig_cnt  = 5'd0;
          announce = 1'b1;
        end
      end
      if (wig_cnt != 5'd0 && since_decay >= time_t'(wiggle_decay_ms)) begin
        last_decay_ms_next = s_now;
        wig_cnt            = wig_cnt - 5'd1;
      end
      wiggle_count_next = wig_cnt[3:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      current_config   <= 4'd1;
      waiting_change   <= 1'b0;
      warning_start_ms <= '0;
      changed_at_ms    <= '0;
      upper_side_hit   <= 1'b0;
      lower_side_hit   <= 1'b0;
      wiggle_count     <= 4'd0;
      last_decay_ms    <= '0;
      result.valid     <= 1'b0;
    end else begin
      if (advance) begin
        current_config   <= current_config_next;
        waiting_change   <= waiting_change_next;
        warning_start_ms <= warning_start_ms_next;
        changed_at_ms    <= changed_at_ms_next;
        upper_side_hit   <= upper_side_hit_next;
        lower_side_hit   <= lower_side_hit_next;
        wiggle_count     <= wiggle_count_next;
        last_decay_ms    <= last_decay_ms_next;
      end
      if (advance) begin
        result.valid <= 1'b1;
      end else if (result.ready) begin
        result.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result.warning_beeps   <= warn;
      result.announce_config <= announce;
      result.config_index    <= current_config_next;
    end
  end

endmodule

@@ test/stick_gesture_config_selector_top_test.sv @@
`timescale 1ns / 1ps

module stick_gesture_config_selector_top_test;
  import sgcs_pkg::*;

  localparam int CycleLimit = 250000;
  localparam int HoldCycles = 200;

  typedef struct {
    logic       warn;
    logic       announce;
    logic [3:0] idx;
  } gesture_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [AddrWidth-1:0] paddr;
  logic [31:0]          pwdata;
  logic [31:0]          prdata;
  logic                 pready;

  sgcs_sample_if smp();
  sgcs_result_if res();

  stick_gesture_config_selector_top dut (
    .clk     (clk),
    .rst     (rst),
    .sample  (smp),
    .result  (res),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #1 clk = ~clk;

  // register copies
  logic [3:0]  cfg_num_configs = NumConfigsReset;
  logic [14:0] cfg_throttle    = ThrottleLimitReset;
  logic [14:0] cfg_change_th   = ChangeThresholdReset;
  logic [14:0] cfg_wiggle_th   = WiggleThresholdReset;
  logic [15:0] cfg_hold        = HoldDelayReset;
  logic [15:0] cfg_rearm       = RearmDelayReset;
  logic [15:0] cfg_decay       = WiggleDecayReset;
  logic [3:0]  cfg_needed      = WigglesNeededReset;

  // gesture state copies
  logic [3:0] cur_cfg    = 4'd1;
  logic       waiting    = 1'b0;
  time_t      warn_start = '0;
  time_t      changed_at = '0;
  logic       upper_hit  = 1'b0;
  logic       lower_hit  = 1'b0;
  int         wiggles    = 0;
  time_t      last_decay = '0;

  gesture_t    gesture_results[$];
  int          errors = 0;
  int          items_sent = 0;
  logic [31:0] stamp_ms = '0;
  bit          src_idle_on = 1'b1;
  bit          sink_idle_on = 1'b1;
  bit          hold_request = 1'b0;
  int unsigned cycle_count = 0;

  function automatic time_t span(time_t now_t, time_t then_t);
    return now_t - then_t;
  endfunction

  function automatic int rand_between(int lo, int hi);
    return lo + int'($urandom_range(0, hi - lo));
  endfunction

  function automatic int unsigned pick_setting(int unsigned lo, int unsigned hi,
                                               int unsigned typ_lo, int unsigned typ_hi);
    case ($urandom_range(0, 3))
      0: return lo;
      1: return hi;
      default: return $urandom_range(typ_lo, typ_hi);
    endcase
  endfunction

  // one sample through the selector, result appended to the pending list
  function automatic void apply_gesture(int tun, int thr, bit busy, time_t now_t);
    int         lim;
    int         cth;
    int         wth;
    int         need;
    logic [3:0] top_idx;
    gesture_t   r;
    lim = int'(cfg_throttle);
    cth = int'(cfg_change_th);
    wth = int'(cfg_wiggle_th);
    need = int'(cfg_needed);
    top_idx = (cfg_num_configs == 4'd0) ? 4'd1 : cfg_num_configs;
    r.warn = 1'b0;
    r.announce = 1'b0;
    if (thr < lim && (tun >= cth || tun <= -cth) && !busy) begin
      if (waiting) begin
        if (span(now_t, warn_start) >= time_t'(cfg_hold)) begin
          changed_at = now_t;
          waiting = 1'b0;
          if (tun >= cth) begin
            cur_cfg = (cur_cfg >= top_idx) ? 4'd1 : cur_cfg + 4'd1;
          end else begin
            cur_cfg = (cur_cfg <= 4'd1) ? top_idx : cur_cfg - 4'd1;
          end
          r.announce = 1'b1;
        end
      end else if (span(now_t, changed_at) >= time_t'(cfg_rearm)) begin
        r.warn = 1'b1;
        warn_start = now_t;
        waiting = 1'b1;
      end
    end
    if (!busy) begin
      if (tun >= wth) upper_hit = 1'b1;
      if (tun <= -wth) lower_hit = 1'b1;
      if (upper_hit && lower_hit) begin
        upper_hit = 1'b0;
        lower_hit = 1'b0;
        wiggles++;
        if (wiggles >= need) begin
          wiggles = 0;
          r.announce = 1'b1;
        end
      end
      if (wiggles > 0 && span(now_t, last_decay) >= time_t'(cfg_decay)) begin
        last_decay = now_t;
        wiggles--;
      end
      wiggles = wiggles & 15;
    end
    r.idx = cur_cfg;
    gesture_results.push_back(r);
  endfunction

  task automatic check_value(string what, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t mismatch %s expected %0h actual %0h", $time, what, want, got);
    end
  endtask

  task automatic send_sample(int tun, int thr, bit busy, logic [31:0] stamp);
    smp.valid <= 1'b1;
    smp.tuner <= 16'(tun);
    smp.thrust <= 16'(thr);
    smp.buzzer_busy <= busy;
    smp.now_ms <= stamp;
    @(posedge clk);
    while (!smp.ready) @(posedge clk);
    apply_gesture(tun, thr, busy, time_t'(stamp));
    items_sent++;
    if (src_idle_on && $urandom_range(0, 4) == 0) begin
      smp.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    smp.valid <= 1'b0;
    while (gesture_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // read a register back and compare with the local copy
  task automatic cfg_check(reg_idx_t r);
    logic [31:0] want;
    case (r)
      REG_NUM_CONFIGS:      want = 32'(cfg_num_configs);
      REG_THROTTLE_LIMIT:   want = 32'(cfg_throttle);
      REG_CHANGE_THRESHOLD: want = 32'(cfg_change_th);
      REG_WIGGLE_THRESHOLD: want = 32'(cfg_wiggle_th);
      REG_HOLD_DELAY:       want = 32'(cfg_hold);
      REG_REARM_DELAY:      want = 32'(cfg_rearm);
      REG_WIGGLE_DECAY:     want = 32'(cfg_decay);
      default:              want = 32'(cfg_needed);
    endcase
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= {r, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    check_value("register", want, prdata);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic cfg_write(reg_idx_t r, logic [31:0] v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {r, 2'b00};
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (r)
      REG_NUM_CONFIGS:      cfg_num_configs = v[3:0];
      REG_THROTTLE_LIMIT:   cfg_throttle = v[14:0];
      REG_CHANGE_THRESHOLD: cfg_change_th = v[14:0];
      REG_WIGGLE_THRESHOLD: cfg_wiggle_th = v[14:0];
      REG_HOLD_DELAY:       cfg_hold = v[15:0];
      REG_REARM_DELAY:      cfg_rearm = v[15:0];
      REG_WIGGLE_DECAY:     cfg_decay = v[15:0];
      default:              cfg_needed = v[3:0];
    endcase
    cfg_check(r);
  endtask

  // a short stick gesture: hold in the change zone, wiggle, rest or noise
  task automatic run_sequence(int unsigned dt_max);
    int kind;
    int len;
    int lim;
    int cth;
    int wth;
    int tun;
    int thr;
    bit up;
    bit side;
    bit busy;
    kind = $urandom_range(0, 9);
    len = $urandom_range(2, 12);
    lim = int'(cfg_throttle);
    cth = int'(cfg_change_th);
    wth = int'(cfg_wiggle_th);
    up = 1'($urandom_range(0, 1));
    for (int i = 0; i < len; i++) begin
      busy = ($urandom_range(0, 9) == 0);
      thr = ($urandom_range(0, 9) == 0) ? rand_between(lim, 32767) : rand_between(-32768, lim - 1);
      case (kind)
        0, 1, 2, 3: begin
          tun = up ? rand_between(cth, 32767) : rand_between(-32768, -cth);
          if ($urandom_range(0, 3) == 0) tun = up ? cth : -cth;
        end
        4, 5, 6: begin
          side = up ^ i[0];
          tun = side ? rand_between(wth, 32767) : rand_between(-32768, -wth);
          if ($urandom_range(0, 3) == 0) tun = side ? wth : -wth;
        end
        7: begin
          tun = rand_between(-wth, wth);
        end
        default: begin
          tun = rand_between(-32768, 32767);
          thr = rand_between(-32768, 32767);
          busy = 1'($urandom_range(0, 1));
          if ($urandom_range(0, 7) == 0) stamp_ms = $urandom();
        end
      endcase
      stamp_ms += $urandom_range(0, dt_max);
      send_sample(tun, thr, busy, stamp_ms);
    end
  endtask

  task automatic test_register_defaults();
    reg_idx_t r;
    r = r.first();
    do begin
      cfg_check(r);
      r = r.next();
    end while (r != r.first());
  endtask

  task automatic test_default_gesture();
    send_sample(32767, -32768, 1'b0, 32'd600);
    send_sample(32767, 982, 1'b0, 32'd2100);
    send_sample(-32768, 983, 1'b0, 32'd2200);
    send_sample(-26214, 0, 1'b1, 32'd2300);
    send_sample(0, 32767, 1'b0, 32'hFFFF_FFFF);
    stamp_ms = 32'hFFFF_FFFF;
  endtask

  task automatic test_config_stepping();
    wait_idle();
    cfg_write(REG_HOLD_DELAY, 32'd0);
    cfg_write(REG_REARM_DELAY, 32'd0);
    cfg_write(REG_NUM_CONFIGS, 32'd3);
    repeat (4) send_sample(26214, -1, 1'b0, stamp_ms);
    repeat (2) send_sample(-26214, -1, 1'b0, stamp_ms);
  endtask

  task automatic test_wiggle_count();
    wait_idle();
    cfg_write(REG_WIGGLE_THRESHOLD, 32'd1000);
    cfg_write(REG_WIGGLES_NEEDED, 32'd2);
    cfg_write(REG_WIGGLE_DECAY, 32'd65535);
    send_sample(1000, 32767, 1'b0, stamp_ms);
    send_sample(-1000, 32767, 1'b0, stamp_ms);
    send_sample(999, 32767, 1'b0, stamp_ms);
    send_sample(2000, 32767, 1'b0, stamp_ms);
    send_sample(-2000, 32767, 1'b0, stamp_ms);
  endtask

  task automatic test_special_cases();
    // zero configurations acts as one, index above the count steps up to one
    wait_idle();
    cfg_write(REG_NUM_CONFIGS, 32'd0);
    repeat (2) send_sample(32767, -32768, 1'b0, stamp_ms);
    wait_idle();
    cfg_write(REG_NUM_CONFIGS, 32'd15);
    repeat (2) send_sample(-32768, -32768, 1'b0, stamp_ms);
    // index above the count steps down by one
    wait_idle();
    cfg_write(REG_NUM_CONFIGS, 32'd2);
    repeat (2) send_sample(-32767, -32768, 1'b0, stamp_ms);
    repeat (2) send_sample(32767, -32768, 1'b0, stamp_ms);
    // zero wiggles needed announces every wiggle
    wait_idle();
    cfg_write(REG_WIGGLES_NEEDED, 32'd0);
    send_sample(1000, 32767, 1'b0, stamp_ms);
    send_sample(-1000, 32767, 1'b0, stamp_ms);
  endtask

  task automatic test_random_gestures();
    int unsigned longest;
    int          target;
    for (int phase = 0; phase < 8; phase++) begin
      wait_idle();
      cfg_write(REG_NUM_CONFIGS, pick_setting(1, 15, 0, 15));
      cfg_write(REG_THROTTLE_LIMIT, pick_setting(0, 32767, 0, 4000));
      cfg_write(REG_CHANGE_THRESHOLD, pick_setting(0, 32767, 16000, 32767));
      cfg_write(REG_WIGGLE_THRESHOLD, pick_setting(0, 32767, 0, 8000));
      cfg_write(REG_HOLD_DELAY, pick_setting(0, 65535, 0, 3000));
      cfg_write(REG_REARM_DELAY, pick_setting(0, 65535, 0, 3000));
      cfg_write(REG_WIGGLE_DECAY, pick_setting(0, 65535, 0, 3000));
      cfg_write(REG_WIGGLES_NEEDED, pick_setting(1, 15, 0, 6));
      src_idle_on = (phase % 3) != 2;
      sink_idle_on = (phase % 4) != 3;
      // sometimes start just short of the time wrap
      if ($urandom_range(0, 3) == 0) stamp_ms = 32'hFFFF_FFFF - $urandom_range(0, 70000);
      longest = 32'(cfg_hold);
      if (32'(cfg_rearm) > longest) longest = 32'(cfg_rearm);
      if (32'(cfg_decay) > longest) longest = 32'(cfg_decay);
      target = items_sent + 180;
      while (items_sent < target) run_sequence(longest / 3 + 1);
    end
  endtask

  task automatic test_backpressure();
    int target;
    wait_idle();
    src_idle_on = 1'b0;
    sink_idle_on = 1'b1;
    hold_request = 1'b1;
    target = items_sent + 60;
    while (items_sent < target) run_sequence(200);
  endtask

  task automatic test_full_rate();
    int target;
    src_idle_on = 1'b0;
    sink_idle_on = 1'b0;
    target = items_sent + 200;
    while (items_sent < target) run_sequence(300);
  endtask

  // result receiver with random stalls and one long hold-off on request
  initial begin
    res.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        res.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
      end else if (sink_idle_on && $urandom_range(0, 5) == 0) begin
        res.ready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
      end
      res.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    gesture_t want;
    if (!rst && res.valid && res.ready) begin
      if (gesture_results.size() == 0) begin
        errors++;
        $display("%0t mismatch unexpected beat expected none actual idx %0d",
                 $time, res.config_index);
      end else begin
        want = gesture_results.pop_front();
        check_value("warning_beeps", 32'(want.warn), 32'(res.warning_beeps));
        check_value("announce_config", 32'(want.announce), 32'(res.announce_config));
        check_value("config_index", 32'(want.idx), 32'(res.config_index));
      end
    end
  end

  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb: failure");
    $finish;
  end

  initial begin
    smp.valid = 1'b0;
    smp.tuner = '0;
    smp.thrust = '0;
    smp.buzzer_busy = 1'b0;
    smp.now_ms = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_register_defaults();
    test_default_gesture();
    test_config_stepping();
    test_wiggle_count();
    test_special_cases();
    test_random_gestures();
    test_backpressure();
    test_full_rate();
    wait_idle();
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
